// ===== hw/rtl/cps_pkg.sv =====
// Shared types, constants and helper functions for the conveyor part sorter control.
// No dependencies; imported by cps_motion and conveyor_part_sorter_control_top.
`timescale 1ns / 1ps

package cps_pkg;

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int SMP_W    = 10;
    localparam int DELAY_W  = 5;
    localparam int DIST_CW  = 7;   // accel/decel distance registers
    localparam int POS_W    = 8;
    localparam int DIST_W   = 10;  // signed tray distance
    localparam int COIL_W   = 6;
    localparam int CLS_W    = 3;
    localparam int CNT_W    = 8;
    localparam int SLOT_W   = 2;   // bin quarter code stored in the ring
    localparam int NCLASS   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Parameter defaults
    localparam int RING_SLOTS_DEF = 4;
    localparam int TRAY_STEPS_DEF = 200;

    // Event codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
    localparam logic [OP_W-1:0] OP_ARRIVE = 3'd1;
    localparam logic [OP_W-1:0] OP_EXIT   = 3'd2;
    localparam logic [OP_W-1:0] OP_HOME   = 3'd3;
    localparam logic [OP_W-1:0] OP_MOTION = 3'd4;
    localparam logic [OP_W-1:0] OP_PAUSE  = 3'd5;

    // Slot codes (bin quarter index)
    localparam logic [SLOT_W-1:0] SLOT_BLACK = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_ALUM  = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_WHITE = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_STEEL = 2'd3;

    // Reported class codes
    localparam logic [CLS_W-1:0] CLS_NONE  = 3'd0;
    localparam logic [CLS_W-1:0] CLS_BLACK = 3'd1;
    localparam logic [CLS_W-1:0] CLS_STEEL = 3'd2;
    localparam logic [CLS_W-1:0] CLS_WHITE = 3'd3;
    localparam logic [CLS_W-1:0] CLS_ALUM  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALUM_MAX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEEL_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL     = 3'd6;

    // Reset values
    localparam logic [SMP_W-1:0]   ALUM_MAX_RST  = 10'd350;
    localparam logic [SMP_W-1:0]   STEEL_MAX_RST = 10'd699;
    localparam logic [SMP_W-1:0]   WHITE_MAX_RST = 10'd945;
    localparam logic [DELAY_W-1:0] MIN_DELAY_RST = 5'd11;
    localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 5'd18;
    localparam logic [DIST_CW-1:0] ACCEL_RST     = 7'd20;
    localparam logic [DIST_CW-1:0] DECEL_RST     = 7'd16;
    localparam logic [SMP_W-1:0]   LOW_RST       = 10'd1023;
    localparam logic [DELAY_W-1:0] PAUSE_DELAY   = 5'd17;

    typedef struct packed {
        logic [DELAY_W-1:0] min_delay;
        logic [DELAY_W-1:0] max_delay;
        logic [DIST_CW-1:0] accel;
        logic [DIST_CW-1:0] decel;
    } t_ramp_cfg;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [1:0]         phase;
        logic [DELAY_W-1:0] delay;
        logic               belt;
        logic               stepped;
    } t_motion;

    function automatic logic [COIL_W-1:0] coil_pattern(input logic [1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            2'd0:    pat = 6'h36;
            2'd1:    pat = 6'h2E;
            2'd2:    pat = 6'h2D;
            default: pat = 6'h35;
        endcase
        return pat;
    endfunction

    function automatic logic [CLS_W-1:0] class_code(input logic [SLOT_W-1:0] slot);
        logic [CLS_W-1:0] c;
        case (slot)
            SLOT_BLACK: c = CLS_BLACK;
            SLOT_ALUM:  c = CLS_ALUM;
            SLOT_WHITE: c = CLS_WHITE;
            default:    c = CLS_STEEL;
        endcase
        return c;
    endfunction

    // Divisible by 3: base-4 digit sum, since 4 is 1 mod 3.
    function automatic logic is_mult3(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[3:2]) + 3'(s[1:0]);
        return (t == 3'd0) || (t == 3'd3) || (t == 3'd6);
    endfunction

endpackage

// ===== hw/rtl/cps_motion.sv =====
// Tray motion step: shortest-path distance to the head bin, delay ramp, position wrap.
// Depends on cps_pkg.
`timescale 1ns / 1ps

module cps_motion import cps_pkg::*; #(
    parameter int TRAY_STEPS = TRAY_STEPS_DEF
) (
    input  logic [SLOT_W-1:0]  i_head_slot,
    input  logic [POS_W-1:0]   i_pos,
    input  logic [1:0]         i_phase,
    input  logic [DELAY_W-1:0] i_delay,
    input  logic               i_belt,
    input  logic               i_blocked,
    input  t_ramp_cfg          i_ramp,
    output t_motion            o_next
);

    localparam logic [POS_W-1:0] BIN_ALUM  = POS_W'(TRAY_STEPS / 4);
    localparam logic [POS_W-1:0] BIN_WHITE = POS_W'((2 * TRAY_STEPS) / 4);
    localparam logic [POS_W-1:0] BIN_STEEL = POS_W'((3 * TRAY_STEPS) / 4);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(TRAY_STEPS - 1);
    localparam logic [POS_W:0]   STEPS_U   = (POS_W+1)'(TRAY_STEPS);
    localparam logic signed [DIST_W-1:0] HALF_S  = DIST_W'(TRAY_STEPS / 2);
    localparam logic signed [DIST_W-1:0] STEPS_S = DIST_W'(TRAY_STEPS);

    logic [POS_W-1:0]          target;
    logic signed [DIST_W-1:0]  dist_raw;
    logic signed [DIST_W-1:0]  path_dist;
    logic [POS_W-1:0]          mag;
    logic                      div3;
    logic [DELAY_W-1:0]        delay_acc;
    logic [DELAY_W-1:0]        delay_dec;
    logic [POS_W:0]            pos_inc;

    always_comb begin
        case (i_head_slot)
            SLOT_BLACK: target = '0;
            SLOT_ALUM:  target = BIN_ALUM;
            SLOT_WHITE: target = BIN_WHITE;
            default:    target = BIN_STEEL;
        endcase
    end

    assign dist_raw = signed'({2'b00, target}) - signed'({2'b00, i_pos});

    always_comb begin
        if (dist_raw >= HALF_S) begin
            path_dist = dist_raw - STEPS_S;
        end else if (dist_raw < -HALF_S) begin
            path_dist = dist_raw + STEPS_S;
        end else begin
            path_dist = dist_raw;
        end
    end

    assign mag  = path_dist[DIST_W-1] ? POS_W'(-path_dist) : POS_W'(path_dist);
    assign div3 = is_mult3(mag);

    // Speed-up test first, slow-down test on the updated delay
    assign delay_acc = (mag > {1'b0, i_ramp.accel} && i_delay > i_ramp.min_delay && div3)
                     ? i_delay - 5'd1 : i_delay;
    assign delay_dec = (mag < {1'b0, i_ramp.decel} && delay_acc < i_ramp.max_delay && div3)
                     ? delay_acc + 5'd1 : delay_acc;

    assign pos_inc = {1'b0, i_pos} + 9'd1;

    always_comb begin
        o_next = '{pos: i_pos, phase: i_phase, delay: i_delay, belt: i_belt, stepped: 1'b0};
        if (target == i_pos) begin
            // aligned: slow delay, belt back on
            o_next.delay = i_ramp.max_delay;
            o_next.belt  = 1'b1;
        end else begin
            if (i_blocked) begin
                o_next.belt = 1'b0;
            end
            o_next.delay   = delay_dec;
            o_next.stepped = 1'b1;
            if (!path_dist[DIST_W-1] && path_dist != '0) begin
                o_next.phase = i_phase + 2'd1;
                o_next.pos   = (pos_inc >= STEPS_U) ? '0 : pos_inc[POS_W-1:0];
            end else begin
                o_next.phase = i_phase - 2'd1;
                o_next.pos   = (i_pos == '0) ? POS_LAST : i_pos - 8'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/conveyor_part_sorter_control_top.sv =====
// Conveyor part sorter control: top level with event decode, ring, counters, output stage.
// Depends on cps_pkg and cps_motion.
// An accepted event transaction has its result on the output register in the following cycle.
// Throughput: one event per cycle while o_in_stall is low; the whole state update is a single combinational pass.
// o_in_stall rises only while a result is held and the output side stalls.
// Reset (i_rst_n low, synchronous): thresholds and ramp registers to defaults, ring and
// counters cleared, tray at 0, delay 18, belt off, not paused, output empty.
`timescale 1ns / 1ps

module conveyor_part_sorter_control_top import cps_pkg::*; #(
    parameter int RING_SLOTS = RING_SLOTS_DEF,
    parameter int TRAY_STEPS = TRAY_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // event channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_op,
    input  logic [SMP_W-1:0]      i_sample,
    input  logic                  i_item_present,
    input  logic                  i_exit_blocked,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COIL_W-1:0]     o_coil_pattern,
    output logic                  o_stepped,
    output logic                  o_belt_on,
    output logic [DELAY_W-1:0]    o_step_delay,
    output logic [POS_W-1:0]      o_tray_position,
    output logic                  o_is_paused,
    output logic [CLS_W-1:0]      o_classified_as,
    output logic [CLS_W-1:0]      o_count_class,
    output logic [CNT_W-1:0]      o_sorted_count,
    output logic [CNT_W-1:0]      o_pending_count,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RING_W = $clog2(RING_SLOTS);
    localparam logic [RING_W-1:0] RING_LAST = RING_W'(RING_SLOTS - 1);

    // ------------------------------------------------------------------
    // Handshakes: output register parts the two sides; a new transaction
    // is taken whenever the held result is empty or leaving this cycle.
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_acc;

    assign o_in_stall  = o_out_valid & i_out_stall;
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign out_acc     = o_out_valid & ~i_out_stall;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SMP_W-1:0] r_alum_max;
    logic [SMP_W-1:0] r_steel_max;
    logic [SMP_W-1:0] r_white_max;
    t_ramp_cfg        r_ramp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alum_max       <= ALUM_MAX_RST;
            r_steel_max      <= STEEL_MAX_RST;
            r_white_max      <= WHITE_MAX_RST;
            r_ramp.min_delay <= MIN_DELAY_RST;
            r_ramp.max_delay <= MAX_DELAY_RST;
            r_ramp.accel     <= ACCEL_RST;
            r_ramp.decel     <= DECEL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ALUM_MAX:  r_alum_max       <= i_cfg_data;
                CFG_STEEL_MAX: r_steel_max      <= i_cfg_data;
                CFG_WHITE_MAX: r_white_max      <= i_cfg_data;
                CFG_MIN_DELAY: r_ramp.min_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_MAX_DELAY: r_ramp.max_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_ACCEL:     r_ramp.accel     <= i_cfg_data[DIST_CW-1:0];
                CFG_DECEL:     r_ramp.decel     <= i_cfg_data[DIST_CW-1:0];
                default: ;     // unmapped index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sorter state
    // ------------------------------------------------------------------
    logic [SMP_W-1:0]   r_low,       n_low;
    logic [SLOT_W-1:0]  r_ring [RING_SLOTS];
    logic [RING_W-1:0]  r_wr_slot,   n_wr_slot;
    logic [RING_W-1:0]  r_rd_slot,   n_rd_slot;
    logic [1:0]         r_phase,     n_phase;
    logic [POS_W-1:0]   r_tray_pos,  n_tray_pos;
    logic [DELAY_W-1:0] r_delay,     n_delay;
    logic               r_paused,    n_paused;
    logic               r_belt,      n_belt;
    logic [CNT_W-1:0]   r_sorted  [NCLASS];
    logic [CNT_W-1:0]   n_sorted  [NCLASS];
    logic [CNT_W-1:0]   r_pending [NCLASS];
    logic [CNT_W-1:0]   n_pending [NCLASS];

    // Decode of the current transaction
    logic               do_classify;
    logic               do_exit;
    logic               do_motion;
    logic [SMP_W-1:0]   low_upd;
    logic [SLOT_W-1:0]  cls_slot;
    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  rpt_slot;
    logic               rpt_en;
    t_motion            mot_next;

    assign head_slot = r_ring[r_rd_slot];
    assign low_upd   = (i_sample < r_low) ? i_sample : r_low;

    // Thresholds tested in order: aluminum, steel, white, else black
    always_comb begin
        if (low_upd <= r_alum_max) begin
            cls_slot = SLOT_ALUM;
        end else if (low_upd <= r_steel_max) begin
            cls_slot = SLOT_STEEL;
        end else if (low_upd <= r_white_max) begin
            cls_slot = SLOT_WHITE;
        end else begin
            cls_slot = SLOT_BLACK;
        end
    end

    cps_motion #(
        .TRAY_STEPS (TRAY_STEPS)
    ) u_motion (
        .i_head_slot (head_slot),
        .i_pos       (r_tray_pos),
        .i_phase     (r_phase),
        .i_delay     (r_delay),
        .i_belt      (r_belt),
        .i_blocked   (i_exit_blocked),
        .i_ramp      (r_ramp),
        .o_next      (mot_next)
    );

    always_comb begin
        do_classify = 1'b0;
        do_exit     = 1'b0;
        do_motion   = 1'b0;
        n_low       = r_low;
        n_wr_slot   = r_wr_slot;
        n_rd_slot   = r_rd_slot;
        n_phase     = r_phase;
        n_tray_pos  = r_tray_pos;
        n_delay     = r_delay;
        n_paused    = r_paused;
        n_belt      = r_belt;
        rpt_en      = 1'b0;
        rpt_slot    = cls_slot;

        unique case (i_op)
            OP_SAMPLE: begin
                n_low = low_upd;
                if (!i_item_present) begin
                    do_classify = 1'b1;
                    rpt_en      = 1'b1;
                    n_wr_slot   = (r_wr_slot == RING_LAST) ? '0 : r_wr_slot + RING_W'(1);
                end
            end
            OP_ARRIVE: begin
                n_low = LOW_RST;
            end
            OP_EXIT: begin
                do_exit   = 1'b1;
                rpt_en    = 1'b1;
                rpt_slot  = head_slot;
                n_rd_slot = (r_rd_slot == RING_LAST) ? '0 : r_rd_slot + RING_W'(1);
            end
            OP_HOME: begin
                n_tray_pos = '0;
            end
            OP_MOTION: begin
                if (!r_paused) begin
                    do_motion  = 1'b1;
                    n_tray_pos = mot_next.pos;
                    n_phase    = mot_next.phase;
                    n_delay    = mot_next.delay;
                    n_belt     = mot_next.belt;
                end
            end
            OP_PAUSE: begin
                n_paused = ~r_paused;
                if (!r_paused) begin
                    n_belt  = 1'b0;
                    n_delay = PAUSE_DELAY;
                end
            end
            default: ;  // unused codes: status only
        endcase
    end

    // Per-class counters, each saturating on its own
    always_comb begin
        for (int k = 0; k < NCLASS; k++) begin
            n_sorted[k]  = r_sorted[k];
            n_pending[k] = r_pending[k];
            if (do_classify && cls_slot == SLOT_W'(k) && r_pending[k] != '1) begin
                n_pending[k] = r_pending[k] + 8'd1;
            end
            if (do_exit && head_slot == SLOT_W'(k)) begin
                if (r_sorted[k] != '1) begin
                    n_sorted[k] = r_sorted[k] + 8'd1;
                end
                if (r_pending[k] != '0) begin
                    n_pending[k] = r_pending[k] - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low      <= LOW_RST;
            r_wr_slot  <= '0;
            r_rd_slot  <= '0;
            r_phase    <= '0;
            r_tray_pos <= '0;
            r_delay    <= MAX_DELAY_RST;
            r_paused   <= 1'b0;
            r_belt     <= 1'b0;
            for (int s = 0; s < RING_SLOTS; s++) begin
                r_ring[s] <= SLOT_BLACK;
            end
            for (int k = 0; k < NCLASS; k++) begin
                r_sorted[k]  <= '0;
                r_pending[k] <= '0;
            end
        end else if (in_acc) begin
            r_low      <= n_low;
            r_wr_slot  <= n_wr_slot;
            r_rd_slot  <= n_rd_slot;
            r_phase    <= n_phase;
            r_tray_pos <= n_tray_pos;
            r_delay    <= n_delay;
            r_paused   <= n_paused;
            r_belt     <= n_belt;
            if (do_classify) begin
                r_ring[r_wr_slot] <= cls_slot;
            end
            for (int k = 0; k < NCLASS; k++) begin
                r_sorted[k]  <= n_sorted[k];
                r_pending[k] <= n_pending[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (in_acc) begin
            o_out_valid <= 1'b1;
        end else if (out_acc) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            o_coil_pattern  <= coil_pattern(n_phase);
            o_stepped       <= do_motion & mot_next.stepped;
            o_belt_on       <= n_belt;
            o_step_delay    <= n_delay;
            o_tray_position <= n_tray_pos;
            o_is_paused     <= n_paused;
            o_classified_as <= do_classify ? class_code(cls_slot) : CLS_NONE;
            o_count_class   <= rpt_en ? class_code(rpt_slot) : CLS_NONE;
            o_sorted_count  <= rpt_en ? n_sorted[rpt_slot] : '0;
            o_pending_count <= rpt_en ? n_pending[rpt_slot] : '0;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tray_pos < POS_W'(TRAY_STEPS))
        else $error("tray position out of range");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted transaction produced no result");

    a_step_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_op != OP_MOTION |=> !o_stepped)
        else $error("step reported for a non-motion event");

    a_step_moves_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && do_motion && mot_next.stepped |=> r_phase != $past(r_phase))
        else $error("step without coil phase change");

    a_class_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_classified_as != CLS_NONE |-> o_count_class == o_classified_as)
        else $error("classified part not the reported class");

endmodule
